/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the alpha unpremultiply / matte unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define AUM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define AUM_ASSERT_IMPLY(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define AUM_ASSERT_NEXT(lbl, cond, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

/* hw/rtl/aum_pkg.sv */
// Package: types and constants of the alpha unpremultiply / matte unit.
package aum_pkg;

   localparam int unsigned ChanW   = 8;
   localparam int unsigned NumW    = 16;
   localparam int unsigned NumChan = 3;
   localparam int unsigned CsrIdxW = 2;
   localparam int unsigned CsrW    = 8;

   localparam logic [ChanW-1:0] CH_MAX     = 8'd255;
   localparam logic [NumW-1:0]  ROUND_HALF = 16'd127;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_KEEP_ALPHA  = 2'd0,
      CSR_MATTE_RED   = 2'd1,
      CSR_MATTE_GREEN = 2'd2,
      CSR_MATTE_BLUE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [ChanW-1:0] in_red;
      logic [ChanW-1:0] in_green;
      logic [ChanW-1:0] in_blue;
      logic [ChanW-1:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [ChanW-1:0] out_red;
      logic [ChanW-1:0] out_green;
      logic [ChanW-1:0] out_blue;
      logic [ChanW-1:0] out_alpha;
   } rsp_type;

   // Channel 0 red, 1 green, 2 blue.
   typedef struct packed {
      logic                          keep_alpha;
      logic [NumChan-1:0][ChanW-1:0] matte;
   } cfg_type;

   typedef struct packed {
      logic [NumW-1:0]  rem;      // division remainder
      logic [ChanW-1:0] quo;      // quotient bits so far
      logic             sat;      // quotient would exceed 255
      logic [NumW-1:0]  mix_num;  // matte*(255-alpha)+127
      logic [ChanW-1:0] pix;      // premultiplied input channel
   } chan_type;

   typedef struct packed {
      logic                         keep_alpha;
      logic [ChanW-1:0]             alpha;
      logic [NumChan-1:0] [$bits(chan_type)-1:0] chan;
   } work_type;

endpackage

/* hw/rtl/aum_front.sv */
// Front stage: numerators, saturation check and matte products.
module aum_front import aum_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  req_type  in_data,
   input  cfg_type  cfg,
   output logic     in_ready,
   output logic     out_valid,
   output work_type out_data,
   input  logic     out_ready
);

   logic                          valid_ff;
   work_type                      work_ff;
   work_type                      work_in;
   logic [NumChan-1:0][ChanW-1:0] pix;
   logic [NumW-1:0]               num      [NumChan];
   logic [NumW-1:0]               mprod    [NumChan];
   chan_type                      ch       [NumChan];
   logic [ChanW-1:0]              inv_alpha;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      pix[0]    = in_data.in_red;
      pix[1]    = in_data.in_green;
      pix[2]    = in_data.in_blue;
      inv_alpha = CH_MAX - in_data.in_alpha;
      work_in.keep_alpha = cfg.keep_alpha;
      work_in.alpha      = in_data.in_alpha;
      for (int i = 0; i < NumChan; i++) begin
         // c*255 + alpha/2, at most 65152
         num[i]   = ({pix[i], 8'h00} - {8'h00, pix[i]}) + {9'h000, in_data.in_alpha[7:1]};
         mprod[i] = 16'(cfg.matte[i]) * 16'(inv_alpha);
         ch[i].rem     = num[i];
         ch[i].quo     = '0;
         ch[i].sat     = (num[i] >= {in_data.in_alpha, 8'h00});
         ch[i].mix_num = mprod[i] + ROUND_HALF;
         ch[i].pix     = pix[i];
         work_in.chan[i] = ch[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = work_ff;

endmodule

/* hw/rtl/aum_div_stage.sv */
// Divider stage: two restoring steps per channel, quotient bits HI_BIT and HI_BIT-1.
module aum_div_stage import aum_pkg::*; #(
   parameter int unsigned HI_BIT = 7
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   output work_type out_data,
   input  logic     out_ready
);

   localparam int unsigned LO_BIT = HI_BIT - 1;

   logic     valid_ff;
   work_type work_ff;
   work_type work_in;
   chan_type ch  [NumChan];
   logic [NumW-1:0] d_hi;
   logic [NumW-1:0] d_lo;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      work_in = in_data;
      d_hi = {8'h00, in_data.alpha} << HI_BIT;
      d_lo = {8'h00, in_data.alpha} << LO_BIT;
      for (int i = 0; i < NumChan; i++) begin
         ch[i] = in_data.chan[i];
         if (ch[i].rem >= d_hi) begin
            ch[i].rem         = ch[i].rem - d_hi;
            ch[i].quo[HI_BIT] = 1'b1;
         end
         if (ch[i].rem >= d_lo) begin
            ch[i].rem         = ch[i].rem - d_lo;
            ch[i].quo[LO_BIT] = 1'b1;
         end
         work_in.chan[i] = ch[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = work_ff;

endmodule

/* hw/rtl/aum_out.sv */
// Output stage: matte composite, saturation, mode select and result register.
module aum_out import aum_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  work_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   output rsp_type  out_data,
   input  logic     out_ready
);

   logic                          valid_ff;
   rsp_type                       rsp_ff;
   rsp_type                       rsp_in;
   chan_type                      ch     [NumChan];
   logic [NumW:0]                 q_sum  [NumChan];
   logic [ChanW-1:0]              q_mix  [NumChan];
   logic [ChanW:0]                s_mix  [NumChan];
   logic [NumChan-1:0][ChanW-1:0] res;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      for (int i = 0; i < NumChan; i++) begin
         ch[i] = in_data.chan[i];
         // x/255 as (x + x/256 + 1)/256, exact for x up to 65152
         q_sum[i] = {1'b0, ch[i].mix_num} + {9'h000, ch[i].mix_num[15:8]} + 17'd1;
         q_mix[i] = q_sum[i][15:8];
         s_mix[i] = {1'b0, ch[i].pix} + {1'b0, q_mix[i]};
         if (in_data.keep_alpha) begin
            if (in_data.alpha == 8'h00) begin
               res[i] = 8'h00;
            end else if (ch[i].sat) begin
               res[i] = CH_MAX;
            end else begin
               res[i] = ch[i].quo;
            end
         end else begin
            res[i] = s_mix[i][ChanW] ? CH_MAX : s_mix[i][ChanW-1:0];
         end
      end
      rsp_in.out_red   = res[0];
      rsp_in.out_green = res[1];
      rsp_in.out_blue  = res[2];
      rsp_in.out_alpha = in_data.keep_alpha ? in_data.alpha : CH_MAX;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = rsp_ff;

endmodule

/* hw/rtl/alpha_unpremultiply_matte_unit.sv */
// Top level of the alpha unpremultiply / matte unit: registers, pipeline and checks.
//
// Takes one premultiplied RGBA8 pixel per beat and returns one pixel per beat, one pixel
// per clock sustained while rsp_stall is low. An accepted req beat passes through a
// front stage (numerators c*255+alpha/2 and matte products), four divider stages of two
// restoring quotient bits each for every channel, and an output stage that finishes the
// matte composite, saturates and selects the mode. Every stage holds its own valid bit and
// loads when it is empty or its successor takes its beat, so bubbles close up and a stalled
// rsp side only backs up the input once all six stages are full. keep_alpha=1 gives
// round(c*255/alpha) clamped at 255 (0 for zero alpha) with alpha passed through;
// keep_alpha=0 gives c + round(matte*(255-alpha)/255) clamped at 255 with alpha 255.
// Mode and matte color are sampled as a pixel enters; write the registers only while the
// unit is empty.
`include "assert_macros.svh"

module alpha_unpremultiply_matte_unit import aum_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // pixel in
   input  logic               req_valid,
   output logic               req_stall,
   input  req_type            req_data,
   // pixel out
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output rsp_type            rsp_data,
   // register writes
   input  logic               csr_we,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CsrW-1:0]    csr_data
);

   localparam int unsigned NumDiv = 4;

   // configuration registers
   logic                          keep_alpha_ff;
   logic [NumChan-1:0][ChanW-1:0] matte_ff;
   cfg_type                       cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_alpha_ff <= 1'b1;
         matte_ff      <= '0;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEEP_ALPHA:  keep_alpha_ff <= csr_data[0];
            CSR_MATTE_RED:   matte_ff[0]   <= csr_data;
            CSR_MATTE_GREEN: matte_ff[1]   <= csr_data;
            CSR_MATTE_BLUE:  matte_ff[2]   <= csr_data;
            default: ;
         endcase
      end
   end

   assign cfg.keep_alpha = keep_alpha_ff;
   assign cfg.matte      = matte_ff;

   // pipeline links: index 0 is front output, NumDiv is last divider output
   logic     link_valid [NumDiv+1];
   logic     link_ready [NumDiv+1];
   work_type link_data  [NumDiv+1];
   logic     front_ready;

   aum_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .cfg       (cfg),
      .in_ready  (front_ready),
      .out_valid (link_valid[0]),
      .out_data  (link_data[0]),
      .out_ready (link_ready[0])
   );

   assign req_stall = !front_ready;

   // quotient bits 7..0, two per stage
   for (genvar s = 0; s < NumDiv; s++) begin : g_div
      aum_div_stage #(
         .HI_BIT (ChanW - 1 - 2 * s)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[s]),
         .in_data   (link_data[s]),
         .in_ready  (link_ready[s]),
         .out_valid (link_valid[s+1]),
         .out_data  (link_data[s+1]),
         .out_ready (link_ready[s+1])
      );
   end

   aum_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[NumDiv]),
      .in_data   (link_data[NumDiv]),
      .in_ready  (link_ready[NumDiv]),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_ready (!rsp_stall)
   );

   // checks
   `AUM_ASSERT(a_stall_only_when_full, !req_stall || (rsp_valid && rsp_stall), "input stalled while output free")
   `AUM_ASSERT_IMPLY(a_zero_alpha_black, rsp_valid && rsp_data.out_alpha == 8'h00, rsp_data.out_red == 8'h00 && rsp_data.out_green == 8'h00 && rsp_data.out_blue == 8'h00, "zero alpha gave nonzero color")
   `AUM_ASSERT_NEXT(a_front_holds_beat, link_valid[0] && !link_ready[0], link_valid[0], "front stage dropped a stalled beat")

endmodule
